FILE: rtl/core/fes_pkg.sv
// ----------------------------------------------------------------------------
// fes_pkg
// Shared widths, reset values, item types and sequencer states for the
// feedback echo with a smoothed delay time.
// ----------------------------------------------------------------------------
package fes_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int GAIN_W      = 16;
    localparam int DELAY_W     = 16;
    localparam int COEFF_W     = 24;
    localparam int FRAC_W      = 24;
    localparam int SMOOTH_W    = DELAY_W + FRAC_W;
    localparam int HALF_W      = SMOOTH_W / 2;
    localparam int PART_W      = HALF_W + COEFF_W;
    localparam int FULL_W      = SMOOTH_W + COEFF_W;
    localparam int DELAY_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int GAIN_SHIFT  = 15;
    localparam int SUM_W       = SAMPLE_W + 4;

    localparam logic [GAIN_W-1:0]  MIX_RESET      = GAIN_W'(16384);
    localparam logic [DELAY_W-1:0] TARGET_RESET   = DELAY_W'(24000);
    localparam logic [GAIN_W-1:0]  FEEDBACK_RESET = GAIN_W'(19661);
    localparam logic [COEFF_W-1:0] COEFF_RESET    = COEFF_W'(1518);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIX      = 2'd0,
        CFG_TARGET   = 2'd1,
        CFG_FEEDBACK = 2'd2,
        CFG_COEFF    = 2'd3
    } fes_cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } fes_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } fes_out_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
    } fes_mem_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_STEP,
        ST_UPDATE,
        ST_READ,
        ST_ECHO,
        ST_MIX,
        ST_FINISH
    } fes_state_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if (v > SUM_W'(SAMPLE_MAX))
            r = SAMPLE_MAX;
        else if (v < SUM_W'(SAMPLE_MIN))
            r = SAMPLE_MIN;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/fes_echo_store.sv
// ----------------------------------------------------------------------------
// fes_echo_store
// Two channel echo memories with registered reads; a wrap flag tracks which
// entries have been written since reset, unwritten entries read as zero.
// ----------------------------------------------------------------------------
module fes_echo_store (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fes_pkg::fes_mem_req_t                 req,
    input  logic signed [fes_pkg::SAMPLE_W-1:0]   wr_left,
    input  logic signed [fes_pkg::SAMPLE_W-1:0]   wr_right,
    output logic signed [fes_pkg::SAMPLE_W-1:0]   tap_left,
    output logic signed [fes_pkg::SAMPLE_W-1:0]   tap_right
);
    import fes_pkg::*;

    logic signed [SAMPLE_W-1:0] mem_left  [DELAY_DEPTH];
    logic signed [SAMPLE_W-1:0] mem_right [DELAY_DEPTH];

    logic signed [SAMPLE_W-1:0] rd_left_reg;
    logic signed [SAMPLE_W-1:0] rd_right_reg;
    logic                       wrapped_reg;
    logic                       wrapped_next;
    logic                       hit_reg;
    logic                       hit_next;

    // left channel
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem_left[req.wr_addr] <= wr_left;
        if (req.rd_en)
            rd_left_reg <= mem_left[req.rd_addr];
    end

    // right channel
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem_right[req.wr_addr] <= wr_right;
        if (req.rd_en)
            rd_right_reg <= mem_right[req.rd_addr];
    end

    // writes run in address order from zero, so below the write pointer is filled
    always_comb
    begin
        wrapped_next = wrapped_reg;
        if (req.wr_en && (req.wr_addr == {ADDR_W{1'b1}}))
            wrapped_next = 1'b1;
        hit_next = hit_reg;
        if (req.rd_en)
            hit_next = wrapped_reg || (req.rd_addr < req.wr_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrapped_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            wrapped_reg <= wrapped_next;
            hit_reg     <= hit_next;
        end
    end

    assign tap_left  = hit_reg ? rd_left_reg  : '0;
    assign tap_right = hit_reg ? rd_right_reg : '0;

endmodule

FILE: rtl/core/feedback_echo_smoothed_delay.sv
// ----------------------------------------------------------------------------
// feedback_echo_smoothed_delay
// Stereo feedback echo; the delay glides toward its target through a
// one-pole smoother, echoes are kept in two delay memories.
//
//   channel   direction   handshake                    payload
//   frame     in          frame_valid / frame_stall    fes_in_t
//   result    out         result_valid / result_stall  fes_out_t
//   cfg       in          cfg_we                       cfg_index, cfg_data
//
// a new frame is taken only in the idle state, after the last one finishes:
// the smoother step goes through one shared 20 x 24 multiplier in two passes,
// then one registered memory read, the echo and the mix products. the
// sequencer holds in its finish state while the output register is full and
// stalled; the next frame may enter while a result waits. no clearing pass
// after reset, the memories track their fill with a wrap flag.
// ----------------------------------------------------------------------------
module feedback_echo_smoothed_delay (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           frame_valid,
    output logic                           frame_stall,
    input  fes_pkg::fes_in_t               frame,
    output logic                           result_valid,
    input  logic                           result_stall,
    output fes_pkg::fes_out_t              result,
    input  logic                           cfg_we,
    input  logic [fes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fes_pkg::CFG_W-1:0]      cfg_data
);
    import fes_pkg::*;

    fes_state_t state_reg;
    fes_state_t state_next;

    logic [GAIN_W-1:0]  mix_reg;
    logic [DELAY_W-1:0] target_reg;
    logic [GAIN_W-1:0]  feedback_reg;
    logic [COEFF_W-1:0] coeff_reg;

    logic [SMOOTH_W-1:0] smooth_reg;
    logic [SMOOTH_W-1:0] smooth_next;
    logic [ADDR_W-1:0]   wpos_reg;
    logic [ADDR_W-1:0]   wpos_next;

    fes_in_t             x_reg;
    logic                up_reg;
    logic [SMOOTH_W-1:0] mag_reg;
    logic [PART_W-1:0]   plo_reg;
    logic [PART_W-1:0]   phi_reg;
    logic [SMOOTH_W-1:0] step_reg;
    logic signed [SAMPLE_W-1:0] echo_l_reg;
    logic signed [SAMPLE_W-1:0] echo_r_reg;
    logic signed [SAMPLE_W+GAIN_W+1:0] mprod_l_reg;
    logic signed [SAMPLE_W+GAIN_W+1:0] mprod_r_reg;

    logic     result_valid_reg;
    logic     result_valid_next;
    fes_out_t result_reg;

    // control
    logic         accept;
    logic         load_out;
    fes_mem_req_t mem_req;

    // datapath
    logic [SMOOTH_W-1:0] target_wide;
    logic                up_now;
    logic [SMOOTH_W-1:0] mag_now;
    logic [HALF_W-1:0]   mul_a;
    logic [PART_W-1:0]   mul_p;
    logic [FULL_W-1:0]   full_sum;
    logic [ADDR_W-1:0]   tap_addr;
    logic signed [SAMPLE_W-1:0] tap_l;
    logic signed [SAMPLE_W-1:0] tap_r;
    logic signed [SAMPLE_W+GAIN_W:0]   fprod_l;
    logic signed [SAMPLE_W+GAIN_W:0]   fprod_r;
    logic signed [SAMPLE_W-1:0] echo_l;
    logic signed [SAMPLE_W-1:0] echo_r;
    logic signed [SAMPLE_W:0]   diff_l;
    logic signed [SAMPLE_W:0]   diff_r;
    logic signed [SAMPLE_W+GAIN_W+1:0] mprod_l;
    logic signed [SAMPLE_W+GAIN_W+1:0] mprod_r;
    fes_out_t    mixed;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_reg      <= MIX_RESET;
            target_reg   <= TARGET_RESET;
            feedback_reg <= FEEDBACK_RESET;
            coeff_reg    <= COEFF_RESET;
        end
        else if (cfg_we)
        begin
            case (fes_cfg_idx_t'(cfg_index))
                CFG_MIX:      mix_reg      <= cfg_data[GAIN_W-1:0];
                CFG_TARGET:   target_reg   <= cfg_data[DELAY_W-1:0];
                CFG_FEEDBACK: feedback_reg <= cfg_data[GAIN_W-1:0];
                CFG_COEFF:    coeff_reg    <= cfg_data[COEFF_W-1:0];
                default:      ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (frame_valid) state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_STEP;
            ST_STEP:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_READ;
            ST_READ:   state_next = ST_ECHO;
            ST_ECHO:   state_next = ST_MIX;
            ST_MIX:    state_next = ST_FINISH;
            ST_FINISH: if (!result_valid_reg || !result_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        frame_stall     = 1'b1;
        accept          = 1'b0;
        load_out        = 1'b0;
        mem_req.rd_en   = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.rd_addr = tap_addr;
        mem_req.wr_addr = wpos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                frame_stall = 1'b0;
                accept      = frame_valid;
            end
            ST_READ:   mem_req.rd_en = 1'b1;
            ST_ECHO:   mem_req.wr_en = 1'b1;
            ST_FINISH: load_out = !result_valid_reg || !result_stall;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // delay smoother
    always_comb
    begin
        target_wide = {target_reg, {FRAC_W{1'b0}}};
        up_now      = target_wide >= smooth_reg;
        mag_now     = up_now ? (target_wide - smooth_reg) : (smooth_reg - target_wide);
        mul_a       = (state_reg == ST_MUL_LO) ? mag_reg[HALF_W-1:0] : mag_reg[SMOOTH_W-1:HALF_W];
        mul_p       = PART_W'(mul_a) * PART_W'(coeff_reg);
        full_sum    = {phi_reg, {HALF_W{1'b0}}} + FULL_W'(plo_reg);
        smooth_next = smooth_reg;
        if (state_reg == ST_UPDATE)
            smooth_next = up_reg ? (smooth_reg + step_reg) : (smooth_reg - step_reg);
        tap_addr    = wpos_reg - ADDR_W'(1) - ADDR_W'(smooth_reg[SMOOTH_W-1:FRAC_W]);
        wpos_next   = (state_reg == ST_ECHO) ? (wpos_reg + ADDR_W'(1)) : wpos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= {TARGET_RESET, {FRAC_W{1'b0}}};
            wpos_reg   <= '0;
        end
        else
        begin
            smooth_reg <= smooth_next;
            wpos_reg   <= wpos_next;
        end
    end

    // echo and mix arithmetic
    always_comb
    begin
        fprod_l = tap_l * $signed({1'b0, feedback_reg});
        fprod_r = tap_r * $signed({1'b0, feedback_reg});
        echo_l  = sat_sample(SUM_W'(x_reg.left_in)
                  + SUM_W'($signed(fprod_l[SAMPLE_W+GAIN_W:GAIN_SHIFT])));
        echo_r  = sat_sample(SUM_W'(x_reg.right_in)
                  + SUM_W'($signed(fprod_r[SAMPLE_W+GAIN_W:GAIN_SHIFT])));
        diff_l  = (SAMPLE_W+1)'(echo_l_reg) - (SAMPLE_W+1)'(x_reg.left_in);
        diff_r  = (SAMPLE_W+1)'(echo_r_reg) - (SAMPLE_W+1)'(x_reg.right_in);
        mprod_l = diff_l * $signed({1'b0, mix_reg});
        mprod_r = diff_r * $signed({1'b0, mix_reg});
        mixed.left_out  = sat_sample(SUM_W'(x_reg.left_in)
                          + SUM_W'($signed(mprod_l_reg[SAMPLE_W+GAIN_W+1:GAIN_SHIFT])));
        mixed.right_out = sat_sample(SUM_W'(x_reg.right_in)
                          + SUM_W'($signed(mprod_r_reg[SAMPLE_W+GAIN_W+1:GAIN_SHIFT])));
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg   <= frame;
            up_reg  <= up_now;
            mag_reg <= mag_now;
        end
        if (state_reg == ST_MUL_LO)
            plo_reg <= mul_p;
        if (state_reg == ST_MUL_HI)
            phi_reg <= mul_p;
        if (state_reg == ST_STEP)
            step_reg <= full_sum[FULL_W-1:FRAC_W];
        if (state_reg == ST_ECHO)
        begin
            echo_l_reg <= echo_l;
            echo_r_reg <= echo_r;
        end
        if (state_reg == ST_MIX)
        begin
            mprod_l_reg <= mprod_l;
            mprod_r_reg <= mprod_r;
        end
        if (load_out)
            result_reg <= mixed;
    end

    // output register
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_out)
            result_valid_next = 1'b1;
        else if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    fes_echo_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mem_req),
        .wr_left   (echo_l),
        .wr_right  (echo_r),
        .tap_left  (tap_l),
        .tap_right (tap_r)
    );

endmodule

FILE: sim/tb_feedback_echo_smoothed_delay.sv
// ----------------------------------------------------------------------------
// tb_feedback_echo_smoothed_delay
// Self-checking bench for the stereo feedback echo. A directed table covers
// sample and gain extremes, a frozen glide and long wrapping delays, then
// random phases, each with fresh register settings. Each accepted frame runs
// through a bit-exact echo model; the mixed frame that comes back is compared
// field by field, in order. Both sides idle at random, bar one steady phase.
// ----------------------------------------------------------------------------
module tb_feedback_echo_smoothed_delay;

    import fes_pkg::*;

    localparam int IDLE_PCT     = 22;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 181;
    localparam int STEADY_PHASE = 3;
    localparam int SETTLE       = 20;
    localparam int CYCLE_LIMIT  = 250000;

    typedef enum bit {ROW_FRAME, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        fes_cfg_idx_t     reg_idx;
        logic [CFG_W-1:0] reg_val;
        fes_in_t          stim;
        bit               typed;
        fes_out_t         want;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              frame_valid = 1'b0;
    logic              frame_stall;
    fes_in_t           frame = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    fes_out_t          result;
    logic              cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;

    bit                steady = 1'b0;
    int                mismatches = 0;
    int                cycles = 0;
    fes_out_t          mixed_due[$];
    fes_out_t          due;
    plan_row_t         plan[$];

    // echo model state
    logic [GAIN_W-1:0]  mix_q;
    logic [DELAY_W-1:0] target_q;
    logic [GAIN_W-1:0]  fb_q;
    logic [COEFF_W-1:0] coeff_q;
    logic [SMOOTH_W-1:0] glide;
    logic [ADDR_W-1:0]  wr_pos;
    bit signed [SAMPLE_W-1:0] echo_line [2][DELAY_DEPTH];

    feedback_echo_smoothed_delay dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame        (frame),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [SAMPLE_W-1:0] clip(input longint v);
        if (v > longint'(SAMPLE_MAX))
            return SAMPLE_MAX;
        if (v < longint'(SAMPLE_MIN))
            return SAMPLE_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic fes_out_t echo_frame(input fes_in_t f);
        logic [SMOOTH_W-1:0] goal;
        logic [63:0] gap;
        logic [ADDR_W-1:0] tap_at;
        logic signed [SAMPLE_W-1:0] lane [2];
        logic signed [SAMPLE_W-1:0] wet [2];
        logic signed [SAMPLE_W-1:0] echo;
        longint x;
        longint tap;
        fes_out_t o;
        goal = {target_q, {FRAC_W{1'b0}}};
        if (goal >= glide)
        begin
            gap = 64'(goal - glide);
            glide = glide + SMOOTH_W'((gap * 64'(coeff_q)) >> FRAC_W);
        end
        else
        begin
            gap = 64'(glide - goal);
            glide = glide - SMOOTH_W'((gap * 64'(coeff_q)) >> FRAC_W);
        end
        tap_at = wr_pos - ADDR_W'(1) - ADDR_W'(glide[SMOOTH_W-1:FRAC_W]);
        lane[0] = f.left_in;
        lane[1] = f.right_in;
        for (int c = 0; c < 2; c++)
        begin
            x = lane[c];
            tap = echo_line[c][tap_at];
            echo = clip(x + ((tap * longint'(fb_q)) >>> GAIN_SHIFT));
            echo_line[c][wr_pos] = echo;
            wet[c] = clip(x + (((longint'(echo) - x) * longint'(mix_q)) >>> GAIN_SHIFT));
        end
        wr_pos = wr_pos + ADDR_W'(1);
        o.left_out = wet[0];
        o.right_out = wet[1];
        return o;
    endfunction

    function automatic plan_row_t frame_row(input logic signed [SAMPLE_W-1:0] l, r);
        plan_row_t row;
        row = '0;
        row.kind = ROW_FRAME;
        row.stim.left_in = l;
        row.stim.right_in = r;
        return row;
    endfunction

    // mixed frame equals the input frame
    function automatic plan_row_t clean_row(input logic signed [SAMPLE_W-1:0] l, r);
        plan_row_t row;
        row = frame_row(l, r);
        row.typed = 1'b1;
        row.want.left_out = l;
        row.want.right_out = r;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input fes_cfg_idx_t idx, input int val);
        plan_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = CFG_W'(val);
        return row;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2, 3: return SAMPLE_W'($signed($urandom_range(0, 8191)) - 4096);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return GAIN_W'(0);
            1: return GAIN_W'(32768);
            2: return GAIN_W'(65535);
            3, 4: return GAIN_W'($urandom_range(0, 32768));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [DELAY_W-1:0] pick_target();
        case ($urandom_range(0, 7))
            0: return DELAY_W'(0);
            1: return DELAY_W'(65535);
            2: return DELAY_W'($urandom);
            default: return DELAY_W'($urandom_range(0, 48));
        endcase
    endfunction

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 5))
            0: return COEFF_W'(0);
            1: return {COEFF_W{1'b1}};
            2: return COEFF_W'($urandom_range(1, 4095));
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    task automatic flag_error(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", what);
    endtask

    task automatic drain();
        frame_valid <= 1'b0;
        while (mixed_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input fes_cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MIX:      mix_q = val[GAIN_W-1:0];
            CFG_TARGET:   target_q = val[DELAY_W-1:0];
            CFG_FEEDBACK: fb_q = val[GAIN_W-1:0];
            CFG_COEFF:    coeff_q = val[COEFF_W-1:0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_frame(input fes_in_t f, input bit typed, input fes_out_t want);
        fes_out_t calc;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            frame_valid <= 1'b0;
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame <= f;
        do
            @(posedge clk);
        while (frame_stall);
        calc = echo_frame(f);
        mixed_due.push_back(typed ? want : calc);
    endtask

    // result side: check, then choose next stall
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (mixed_due.size() == 0)
            begin
                flag_error($sformatf("unexpected item left_out %0d right_out %0d",
                                     result.left_out, result.right_out));
            end
            else
            begin
                due = mixed_due.pop_front();
                if (result.left_out !== due.left_out)
                    flag_error($sformatf("left_out expected %0d got %0d",
                                         due.left_out, result.left_out));
                if (result.right_out !== due.right_out)
                    flag_error($sformatf("right_out expected %0d got %0d",
                                         due.right_out, result.right_out));
            end
        end
        result_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        fes_in_t pick;
        mix_q = MIX_RESET;
        target_q = TARGET_RESET;
        fb_q = FEEDBACK_RESET;
        coeff_q = COEFF_RESET;
        glide = {TARGET_RESET, {FRAC_W{1'b0}}};
        wr_pos = '0;

        // reset values, taps still empty
        plan.push_back(clean_row(24'sh000000, 24'sh000000));
        plan.push_back(clean_row(SAMPLE_MAX, SAMPLE_MIN));
        plan.push_back(clean_row(SAMPLE_MIN, SAMPLE_MAX));
        plan.push_back(clean_row(-24'sd1, 24'sd1));
        plan.push_back(clean_row(24'sh555555, 24'shAAAAAA));
        // instant glide to zero delay, gains near 2.0
        plan.push_back(reg_row(CFG_TARGET, 0));
        plan.push_back(reg_row(CFG_COEFF, 24'hFFFFFF));
        plan.push_back(reg_row(CFG_FEEDBACK, 65535));
        plan.push_back(reg_row(CFG_MIX, 65535));
        plan.push_back(frame_row(SAMPLE_MAX, SAMPLE_MIN));
        plan.push_back(frame_row(SAMPLE_MAX, SAMPLE_MIN));
        plan.push_back(frame_row(SAMPLE_MIN, SAMPLE_MAX));
        plan.push_back(frame_row(24'sh400000, -24'sh400000));
        plan.push_back(frame_row(24'sh000000, 24'sh000000));
        plan.push_back(frame_row(24'sd1, -24'sd1));
        // dry only
        plan.push_back(reg_row(CFG_MIX, 0));
        plan.push_back(clean_row(SAMPLE_MAX, SAMPLE_MIN));
        plan.push_back(clean_row(24'sh123456, -24'sh123456));
        // wet only, no feedback
        plan.push_back(reg_row(CFG_FEEDBACK, 0));
        plan.push_back(reg_row(CFG_MIX, 32768));
        plan.push_back(clean_row(SAMPLE_MIN, SAMPLE_MAX));
        plan.push_back(clean_row(24'sh2AAAAA, 24'sh555555));
        // frozen glide
        plan.push_back(reg_row(CFG_COEFF, 0));
        plan.push_back(reg_row(CFG_TARGET, 65535));
        plan.push_back(reg_row(CFG_FEEDBACK, 32768));
        plan.push_back(frame_row(24'sh300000, -24'sh300000));
        plan.push_back(frame_row(SAMPLE_MAX, 24'sh000001));
        plan.push_back(frame_row(-24'sh7FFFFF, SAMPLE_MIN));
        // longest delay, tap wraps round the memory
        plan.push_back(reg_row(CFG_COEFF, 24'hFFFFFF));
        plan.push_back(frame_row(24'sh0F0F0F, -24'sh0F0F0F));
        plan.push_back(frame_row(SAMPLE_MIN, SAMPLE_MAX));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                send_frame(plan[i].stim, plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            steady <= (p == STEADY_PHASE);
            write_reg(CFG_MIX, {8'($urandom), pick_gain()});
            write_reg(CFG_TARGET, {8'($urandom), pick_target()});
            write_reg(CFG_FEEDBACK, {8'($urandom), pick_gain()});
            write_reg(CFG_COEFF, pick_coeff());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    drain();
                pick.left_in = pick_sample();
                pick.right_in = pick_sample();
                send_frame(pick, 1'b0, '0);
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && mixed_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/fes_pkg.sv
rtl/core/fes_echo_store.sv
rtl/core/feedback_echo_smoothed_delay.sv
sim/tb_feedback_echo_smoothed_delay.sv
